FILE: design/lprt_pkg.sv
// ============================================================================
// lprt_pkg: shared types and constants for the linear parameter ramp table
// Holds the request and result structs, action codes and table sizes.
// ============================================================================
package lprt_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int SLOT_W      = 6;
    localparam int CNT_W       = 7;
    localparam int VALUE_W     = 32;
    localparam int STEP_W      = 48;
    localparam int REM_W       = 16;

    localparam logic [2:0] ACT_DEFINE  = 3'd0;
    localparam logic [2:0] ACT_RAMP    = 3'd1;
    localparam logic [2:0] ACT_SET     = 3'd2;
    localparam logic [2:0] ACT_ADVANCE = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    localparam logic REG_SLOT_COUNT  = 1'b0;
    localparam logic REG_RAMP_LENGTH = 1'b1;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         slot_index;
        logic signed [31:0] new_value;
        logic signed [31:0] limit_low;
        logic signed [31:0] limit_high;
        logic [15:0]        advance_count;
    } t_req;

    typedef struct packed {
        logic signed [31:0] value_now;
        logic signed [31:0] value_target;
        logic               slot_ramping;
        logic               any_ramping;
        logic               status;
    } t_res;

endpackage

FILE: design/linear_parameter_ramp_table.sv
// ============================================================================
// linear_parameter_ramp_table: table of linearly ramped parameter slots
// Slot state lives in one synchronous memory and is updated by
// read-modify-write from a small sequencer.
// Usage: raise i_start with a request on i_req while o_busy is low; the
// request is taken at that edge and o_busy stays high until its result.
// Exactly one result appears on o_res with o_done high for one cycle. The
// receiver cannot hold results off, so the output never stalls.
// A read, an unknown action, a bad index or an advance by zero reads the
// slot and answers. A define, an immediate set or a ramp onto the current
// value writes the slot back and then reads it again; any other ramp first
// waits for the bit-serial step division before the write back.
// An advance walks every slot in use in turn (read, two multiply
// steps, write back, next slot) and then reads the addressed slot.
// o_busy falls in the same cycle as o_done rises, so the next request
// can be taken while o_done is high.
// Ramping flags in flip-flops are cleared by reset, so a slot never written
// counts as idle; the memory contents are undefined after reset.
// Configuration writes must only occur while the block is idle. Reset is
// synchronous and active low; it sets slot_count to 0, ramp_length to 480.
// ============================================================================
module linear_parameter_ramp_table
    import lprt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    typedef struct packed {
        logic signed [31:0] cur;
        logic signed [31:0] tgt;
        logic signed [47:0] step;
        logic [15:0]        rem;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_slot;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_MOD   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_DWAIT = 4'd4;
    localparam logic [3:0] ST_WR    = 4'd5;
    localparam logic [3:0] ST_ARD   = 4'd6;
    localparam logic [3:0] ST_AMUL  = 4'd7;
    localparam logic [3:0] ST_AWR   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_AMUL2 = 4'd11;

    t_slot r_mem [NUM_SLOTS];
    t_slot r_rd;
    t_slot r_wd;
    logic [SLOT_W-1:0] r_raddr;
    logic  [3:0]  r_state;
    t_req         r_req;
    logic [6:0]   r_slot_count;
    logic [15:0]  r_ramp_len;
    logic [NUM_SLOTS-1:0] r_ramping;
    logic [6:0]   r_walk;
    logic [15:0]  r_k;
    logic [39:0]  r_plo;
    logic signed [40:0] r_phi;
    logic signed [64:0] r_prod;
    logic         r_ok;
    logic         r_div_go;
    logic         w_div_done;
    logic signed [49:0] w_quo;
    logic signed [49:0] r_num;
    logic [6:0]   w_use;
    logic [15:0]  w_len;
    logic signed [31:0] w_clamp;
    logic signed [32:0] w_diff;
    logic signed [64:0] w_sum;
    logic signed [48:0] w_delta;
    logic signed [49:0] w_newv;
    logic signed [31:0] w_satv;
    logic [15:0]  w_rrem;
    logic [15:0]  w_left;
    logic [15:0]  w_kmin;
    t_slot        w_awd;

    assign w_use = (r_slot_count > 7'(NUM_SLOTS)) ? 7'(NUM_SLOTS) : r_slot_count;
    assign w_len = (r_ramp_len == 16'd0) ? 16'd1 : r_ramp_len;
    assign o_busy = (r_state != ST_IDLE);

    // Clamp of the request value into the slot limits; high wins.
    always_comb begin
        w_clamp = r_req.new_value;
        if (w_clamp < r_rd.lo) w_clamp = r_rd.lo;
        if (w_clamp > r_rd.hi) w_clamp = r_rd.hi;
    end
    assign w_diff = 33'(w_clamp) - 33'(r_rd.cur);

    // Remaining count of the walked slot; a slot whose flag is clear is idle.
    assign w_rrem = r_ramping[r_raddr] ? r_rd.rem : 16'd0;

    // Advance arithmetic: round the scaled product, add, saturate.
    assign w_kmin  = (r_req.advance_count < w_rrem) ? r_req.advance_count : w_rrem;
    assign w_sum   = r_prod + 65'sd32768;
    assign w_delta = 49'(w_sum >>> 16);
    assign w_newv  = 50'(r_rd.cur) + 50'(w_delta);
    assign w_satv  = (w_newv > 50'sd2147483647) ? 32'sh7fffffff :
                     (w_newv < -50'sd2147483648) ? 32'sh80000000 : 32'(w_newv);
    assign w_left  = w_rrem - r_k;

    lprt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (w_len),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Advance writeback value, applied as memory write data in ST_AWR.
    always_comb begin
        w_awd = r_rd;
        if (w_rrem != 16'd0) begin
            w_awd.rem = w_left;
            w_awd.cur = (w_left == 16'd0) ? r_rd.tgt : w_satv;
        end
    end

    // Slot memory with registered read.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_raddr];
        if (r_state == ST_WR) begin
            r_mem[r_raddr] <= r_wd;
        end else if (r_state == ST_AWR) begin
            r_mem[r_raddr] <= w_awd;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_ramp_len   <= 16'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SLOT_COUNT:  r_slot_count <= i_cfg_data[6:0];
                REG_RAMP_LENGTH: r_ramp_len   <= i_cfg_data;
                default:         r_ramp_len   <= r_ramp_len;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ramping <= '0;
            o_done    <= 1'b0;
            r_div_go  <= 1'b0;
        end else begin
            o_done   <= 1'b0;
            r_div_go <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_ok    <= (7'(i_req.slot_index) < w_use);
                        r_raddr <= i_req.slot_index;
                        if (i_req.action == ACT_ADVANCE &&
                            i_req.advance_count != 16'd0 && w_use != 7'd0) begin
                            r_walk  <= 7'd0;
                            r_raddr <= '0;
                            r_state <= ST_ARD;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD: r_state <= ST_MOD;
                ST_MOD: begin
                    r_wd    <= r_rd;
                    r_state <= ST_OUT;
                    if (r_ok) begin
                        case (r_req.action)
                            ACT_DEFINE: begin
                                r_wd.lo   <= r_req.limit_low;
                                r_wd.hi   <= r_req.limit_high;
                                r_wd.cur  <= r_req.new_value;
                                r_wd.tgt  <= r_req.new_value;
                                r_wd.rem  <= '0;
                                r_wd.step <= '0;
                                r_state   <= ST_WR;
                            end
                            ACT_SET: begin
                                r_wd.cur  <= w_clamp;
                                r_wd.tgt  <= w_clamp;
                                r_wd.rem  <= '0;
                                r_wd.step <= '0;
                                r_state   <= ST_WR;
                            end
                            ACT_RAMP: begin
                                r_wd.tgt <= w_clamp;
                                if (w_diff == 33'sd0) begin
                                    r_wd.rem  <= '0;
                                    r_wd.step <= '0;
                                    r_state   <= ST_WR;
                                end else begin
                                    r_num    <= {w_diff[32], w_diff, 16'd0};
                                    r_div_go <= 1'b1;
                                    r_state  <= ST_DIV;
                                end
                            end
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_DIV: r_state <= ST_DWAIT;
                ST_DWAIT: begin
                    if (w_div_done) begin
                        r_wd.rem <= w_len;
                        if (w_quo > 50'sh7fffffffffff)
                            r_wd.step <= 48'sh7fffffffffff;
                        else if (w_quo < -50'sh800000000000)
                            r_wd.step <= 48'sh800000000000;
                        else
                            r_wd.step <= 48'(w_quo);
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    r_ramping[r_raddr] <= (r_wd.rem != 16'd0);
                    r_state <= ST_FIN;
                end
                ST_ARD: r_state <= ST_AMUL;
                ST_AMUL: begin
                    // Split the step into two halves for two narrow products.
                    r_k     <= w_kmin;
                    r_plo   <= 40'(r_rd.step[23:0]) * 40'(w_kmin);
                    r_phi   <= 41'($signed(r_rd.step[47:24])) * $signed({25'd0, w_kmin});
                    r_state <= ST_AMUL2;
                end
                ST_AMUL2: begin
                    r_prod  <= (65'(r_phi) <<< 24) + 65'($signed({1'b0, r_plo}));
                    r_state <= ST_AWR;
                end
                ST_AWR: begin
                    // Written this cycle from w_awd.
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (r_req.action == ACT_ADVANCE && r_walk < w_use) begin
                        if (r_walk + 7'd1 < w_use) begin
                            r_walk  <= r_walk + 7'd1;
                            r_raddr <= SLOT_W'(r_walk + 7'd1);
                            r_state <= ST_ARD;
                        end else begin
                            r_walk  <= w_use;
                            r_raddr <= r_req.slot_index;
                            r_state <= ST_RD;
                        end
                    end else begin
                        r_raddr <= r_req.slot_index;
                        r_state <= ST_RD;
                        r_req.action <= ACT_READ;
                    end
                end
                ST_OUT: begin
                    o_done <= 1'b1;
                    o_res.value_now    <= r_ok ? r_rd.cur : '0;
                    o_res.value_target <= r_ok ? r_rd.tgt : '0;
                    o_res.slot_ramping <= r_ok & r_ramping[r_req.slot_index];
                    o_res.any_ramping  <= |(r_ramping &
                                          ((NUM_SLOTS)'(1) << w_use) - (NUM_SLOTS)'(1) |
                                          ((w_use == 7'(NUM_SLOTS)) ? r_ramping : '0));
                    o_res.status       <= ~r_ok;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase

            // Ramping flag of the walked slot follows its new count.
            if (r_state == ST_AWR) begin
                if (w_rrem != 16'd0) begin
                    r_ramping[r_raddr] <= (w_left != 16'd0);
                end
            end
        end
    end

endmodule

FILE: design/lprt_div.sv
// ============================================================================
// lprt_div: restoring divider for the ramp step
// Divides a signed 50-bit dividend by an unsigned 16-bit divisor, one
// quotient bit per cycle, truncating toward zero.
// ============================================================================
module lprt_div
    import lprt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [49:0] i_num,
    input  logic [15:0]        i_den,
    output logic               o_done,
    output logic signed [49:0] o_quo
);

    logic [49:0] r_q;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic [16:0] w_try;
    logic [16:0] w_sub;

    // Shift in the next dividend bit and try a subtraction.
    assign w_try = {r_rem[15:0], r_q[49]};
    assign w_sub = w_try - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_neg  <= i_num[49];
                r_q    <= i_num[49] ? 50'(-i_num) : i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_sub[16]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[48:0], 1'b1};
                end else begin
                    r_rem <= w_try;
                    r_q   <= {r_q[48:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd49) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

FILE: sim/linear_parameter_ramp_table_tb.sv
// ============================================================================
// linear_parameter_ramp_table_tb: self-checking bench for the ramp table
// Runs the table through several slot count and ramp length settings with
// directed and random requests. A behavioral model of the slot table
// predicts every result, and a monitor checks each one in order.
// ============================================================================
`timescale 1ns / 1ps

module linear_parameter_ramp_table_tb;
    import lprt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_req        i_req = '0;
    logic        o_done;
    t_res        o_res;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [15:0] i_cfg_data = '0;

    linear_parameter_ramp_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Requests waiting to be driven and results the table model predicts.
    t_req request_queue[$];
    t_res pending_results[$];

    // Table model state.
    longint      slot_value[NUM_SLOTS];
    longint      slot_target[NUM_SLOTS];
    longint      slot_step[NUM_SLOTS];
    int unsigned slot_left[NUM_SLOTS];
    longint      slot_low[NUM_SLOTS];
    longint      slot_high[NUM_SLOTS];
    bit          slot_loaded[NUM_SLOTS];
    int unsigned model_count = 0;
    int unsigned model_length = 480;

    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned phases_run = 0;
    int unsigned idle_cycles = 0;
    bit          calm = 1'b0;

    localparam longint STEP_HI = (longint'(1) <<< 47) - 1;
    localparam longint STEP_LO = -STEP_HI - 1;

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic int unsigned slots_active();
        return model_count > NUM_SLOTS ? NUM_SLOTS : model_count;
    endfunction

    function automatic longint clamp_to(int s, longint v);
        if (v < slot_low[s]) v = slot_low[s];
        if (v > slot_high[s]) v = slot_high[s];
        return v;
    endfunction

    // Step per sample with 16 extra fraction bits, saturated to 48 bits.
    function automatic void start_ramp(int s);
        longint len, diff, q, r, st;
        len = model_length == 0 ? 1 : longint'(model_length);
        if (slot_value[s] == slot_target[s]) begin
            slot_left[s] = 0;
            slot_step[s] = 0;
            return;
        end
        diff = slot_target[s] - slot_value[s];
        q = diff / len;
        r = diff % len;
        if (q > 64'sd2147483647) st = STEP_HI;
        else if (q < -64'sd2147483648) st = STEP_LO;
        else begin
            st = q * 65536 + (r * 65536) / len;
            if (st > STEP_HI) st = STEP_HI;
            if (st < STEP_LO) st = STEP_LO;
        end
        slot_left[s] = int'(len);
        slot_step[s] = st;
    endfunction

    // Moves every ramping slot in use forward, snapping at the ramp end.
    function automatic void advance_slots(int unsigned n);
        int unsigned k;
        longint delta;
        if (n == 0) return;
        for (int s = 0; s < slots_active(); s++) begin
            if (slot_left[s] == 0) continue;
            k = n < slot_left[s] ? n : slot_left[s];
            delta = (slot_step[s] * longint'(k) + 32768) >>> 16;
            slot_value[s] = sat_word(slot_value[s] + delta);
            slot_left[s] -= k;
            if (slot_left[s] == 0) slot_value[s] = slot_target[s];
        end
    endfunction

    function automatic t_res predict_request(t_req r);
        t_res res;
        int s;
        bit ok;
        longint nv, c;
        s = int'(r.slot_index);
        ok = s < slots_active();
        nv = sat_word(longint'($signed(r.new_value)));
        if (r.action == ACT_ADVANCE) begin
            advance_slots(32'(r.advance_count));
        end else if (ok && r.action == ACT_DEFINE) begin
            slot_low[s] = longint'($signed(r.limit_low));
            slot_high[s] = longint'($signed(r.limit_high));
            slot_value[s] = nv;
            slot_target[s] = nv;
            slot_left[s] = 0;
            slot_step[s] = 0;
            slot_loaded[s] = 1'b1;
        end else if (ok && r.action == ACT_RAMP) begin
            slot_target[s] = clamp_to(s, nv);
            start_ramp(s);
        end else if (ok && r.action == ACT_SET) begin
            c = clamp_to(s, nv);
            slot_value[s] = c;
            slot_target[s] = c;
            slot_left[s] = 0;
            slot_step[s] = 0;
        end
        res = '0;
        for (int i = 0; i < slots_active(); i++)
            if (slot_left[i] != 0) res.any_ramping = 1'b1;
        if (ok) begin
            res.value_now = 32'(slot_value[s]);
            res.value_target = 32'(slot_target[s]);
            res.slot_ramping = slot_left[s] != 0;
        end
        res.status = !ok;
        return res;
    endfunction

    // Queues a request; one to a slot in use never loaded becomes a define.
    task automatic push_request(t_req r);
        if (r.slot_index < slots_active() && !slot_loaded[r.slot_index])
            r.action = ACT_DEFINE;
        pending_results.insert(pending_results.size(), predict_request(r));
        request_queue.insert(request_queue.size(), r);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        int unsigned w, len;
        r = '0;
        w = $urandom_range(0, 99);
        if (w < 14) r.action = ACT_DEFINE;
        else if (w < 44) r.action = ACT_RAMP;
        else if (w < 54) r.action = ACT_SET;
        else if (w < 78) r.action = ACT_ADVANCE;
        else if (w < 94) r.action = ACT_READ;
        else r.action = 3'($urandom_range(5, 7));
        if (slots_active() > 0 && $urandom_range(0, 9) != 0)
            r.slot_index = 6'($urandom_range(0, slots_active() - 1));
        else
            r.slot_index = 6'($urandom);
        r.new_value = pick_value();
        if ($urandom_range(0, 5) == 0) begin
            r.limit_low = $urandom;
            r.limit_high = $urandom;
        end else begin
            r.limit_low = 32'($signed($urandom_range(0, 1500000)) - 1500000);
            r.limit_high = 32'($signed($urandom_range(0, 1500000)));
        end
        len = model_length == 0 ? 1 : model_length;
        w = $urandom_range(0, 9);
        if (w < 6) r.advance_count = 16'($urandom_range(0, len * 2 > 65535 ? 65535 : len * 2));
        else if (w < 8) r.advance_count = 16'($urandom_range(0, 3));
        else if (w < 9) r.advance_count = 16'hFFFF;
        else r.advance_count = 16'($urandom);
        return r;
    endfunction

    task automatic write_reg(logic idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Applies a setting once the table has answered every queued request.
    task automatic set_phase(logic [15:0] count, logic [15:0] length);
        while (request_queue.size() != 0 || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_SLOT_COUNT, count);
        write_reg(REG_RAMP_LENGTH, length);
        model_count = 32'(count[6:0]);
        model_length = 32'(length);
        phases_run++;
    endtask

    task automatic directed_request(logic [2:0] act, int s, logic [31:0] v,
                                    logic [31:0] lo, logic [31:0] hi, int n);
        t_req r;
        r.action = act;
        r.slot_index = 6'(s);
        r.new_value = v;
        r.limit_low = lo;
        r.limit_high = hi;
        r.advance_count = 16'(n);
        push_request(r);
    endtask

    // Driver: presents the next request once the previous one is taken.
    always @(posedge i_clk) begin
        int unsigned gap;
        bit took;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap = 0;
        end else begin
            took = i_start && !o_busy;
            if (took) begin
                items_sent++;
                if ($urandom_range(0, 19) == 0) calm = !calm;
                gap = calm ? 0 : $urandom_range(0, 10);
            end
            if (!i_start || took) begin
                if (gap > 0) begin
                    gap--;
                    i_start <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    i_start <= 1'b1;
                    i_req <= request_queue.pop_front();
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result against the oldest prediction.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_done || (i_start && !o_busy)) idle_cycles = 0;
            else idle_cycles++;
            if (o_done) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %h", o_res);
                end else begin
                    want = pending_results.pop_front();
                    if (o_res.value_now !== want.value_now
                        || o_res.value_target !== want.value_target
                        || o_res.slot_ramping !== want.slot_ramping
                        || o_res.any_ramping !== want.any_ramping
                        || o_res.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d now %h/%h target %h/%h ramp %b/%b any %b/%b status %b/%b",
                                     results_seen, want.value_now, o_res.value_now,
                                     want.value_target, o_res.value_target,
                                     want.slot_ramping, o_res.slot_ramping,
                                     want.any_ramping, o_res.any_ramping,
                                     want.status, o_res.status);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no request or result moved for %0d cycles", idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stimulus: setting phases, with directed requests in the first, then random ones.
    initial begin
        logic [15:0] counts[9];
        logic [15:0] lengths[9];
        counts = '{16'd64, 16'd64, 16'd8, 16'd0, 16'd100, 16'd64, 16'd1, 16'd33, 16'd64};
        lengths = '{16'd4, 16'd1, 16'd0, 16'd480, 16'd16, 16'd65535, 16'd3, 16'd200,
                    16'd40};
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_left[s] = 0;
            slot_loaded[s] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 9; p++) begin
            set_phase(counts[p], lengths[p]);
            if (p == 0) begin
                // Full-range limits, crossed limits and extreme targets.
                directed_request(ACT_DEFINE, 0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
                directed_request(ACT_DEFINE, 63, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 0);
                directed_request(ACT_RAMP, 0, 32'h7FFF_FFFF, 0, 0, 0);
                directed_request(ACT_ADVANCE, 0, 0, 0, 0, 0);
                directed_request(ACT_ADVANCE, 0, 0, 0, 0, 1);
                directed_request(ACT_ADVANCE, 63, 0, 0, 0, 65535);
                directed_request(ACT_RAMP, 0, 32'h8000_0000, 0, 0, 0);
                directed_request(ACT_ADVANCE, 0, 0, 0, 0, 3);
                directed_request(ACT_READ, 0, 0, 0, 0, 0);
                // A repeated ramp to the same target starts the ramp anew.
                directed_request(ACT_RAMP, 63, 32'h0005_0000, 0, 0, 0);
                directed_request(ACT_RAMP, 63, 32'h0005_0000, 0, 0, 0);
                directed_request(ACT_SET, 63, 32'h8000_0000, 0, 0, 0);
                directed_request(ACT_SET, 0, 32'h1234_5678, 0, 0, 0);
                directed_request(ACT_RAMP, 0, 32'hFFFF_FFFF, 0, 0, 0);
                directed_request(ACT_ADVANCE, 0, 0, 0, 0, 2);
                directed_request(3'd5, 0, 0, 0, 0, 0);
                directed_request(3'd7, 63, 0, 0, 0, 0);
                directed_request(ACT_DEFINE, 0, 32'h8000_0000, 32'h0, 32'h1, 0);
                directed_request(ACT_READ, 0, 0, 0, 0, 0);
            end
            for (int i = 0; i < 78; i++) push_request(random_request());
        end

        while (request_queue.size() != 0 || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d setting phases with %0d requests and %0d results checked.",
                 phases_run, items_sent, results_seen);
        $display("Mismatches found: %0d", mismatches + pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
